// File: sv/grs_pkg.sv
// grs_pkg: shared types and constants for the group reverse stream block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package grs_pkg;

    localparam int VALUE_W = 32;   // width of one list element
    localparam int GSIZE_W = 5;    // width of the group size register

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd2;

    // Controller -> datapath per-cycle commands
    typedef struct packed {
        logic wr_en;      // store the accepted item in the group buffer
        logic rd_en;      // read one buffered element for output
        logic run_end;    // tag for the element being read: last of its run
        logic list_end;   // tag for the element being read: last of the list
    } grs_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic room;       // output stage can take one more read this cycle
    } grs_status_t;

endpackage : grs_pkg

`default_nettype wire

// File: sv/group_reverse_stream.sv
// group_reverse_stream: reverses a stream of 32-bit values in groups of k.
// Accept writes each item into the buffer RAM. A group of n results is then read
// back at one element per cycle while the output stage has room, through the RAM
// read register and the output head register to m_tvalid. The single buffer takes
// no input while a group drains.
// Reset (aresetn, synchronous, active low) empties the group and sets k = 2.
`default_nettype none

module group_reverse_stream
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire [GSIZE_W-1:0]   cfg_wr_data,   // group_size
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [VALUE_W-1:0]   s_tdata,       // [31:0] value
    input  wire                 s_tlast,       // is_final
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [VALUE_W-1:0]  m_tdata,       // [31:0] out_value
    output logic                m_tlast,       // run_end
    output logic                m_tuser        // [0] list_end
);

    localparam int AW = $clog2(MAX_GROUP);

    grs_cmd_t    cmd;
    grs_status_t status;
    logic [AW-1:0] wr_addr, rd_addr;

    grs_ctrl #(
        .MAX_GROUP(MAX_GROUP)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tlast    (s_tlast),
        .status     (status),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    grs_datapath #(
        .MAX_GROUP(MAX_GROUP)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .wr_data (s_tdata),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule : group_reverse_stream

`default_nettype wire

// File: sv/grs_ram.sv
// grs_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`default_nettype none

module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]         wr_data,
    input  wire                     rd_en,
    input  wire [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : grs_ram

`default_nettype wire

// File: sv/grs_datapath.sv
// grs_datapath: group buffer RAM, read pipeline tag stage and a two-entry
// output register with skid. Depends on grs_pkg and grs_ram.
`default_nettype none

module grs_datapath
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  grs_cmd_t                    cmd,
    input  wire [$clog2(MAX_GROUP)-1:0] wr_addr,
    input  wire [$clog2(MAX_GROUP)-1:0] rd_addr,
    input  wire [VALUE_W-1:0]           wr_data,
    output grs_status_t                 status,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [VALUE_W-1:0]          m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    logic [VALUE_W-1:0] ram_q;

    // Tags that travel alongside the RAM read
    logic pend_v_reg, pend_run_reg, pend_list_reg;

    // Output stage: head register and skid register
    logic               out_v_reg, out_run_reg, out_list_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic               skid_v_reg, skid_run_reg, skid_list_reg;
    logic [VALUE_W-1:0] skid_data_reg;

    logic       pop;
    logic [1:0] occ;

    grs_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_GROUP)
    ) u_buf (
        .aclk   (aclk),
        .wr_en  (cmd.wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    assign pop = out_v_reg & m_tready;

    // Slots in use after this cycle's pop, counting the read in flight
    assign occ = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(pend_v_reg) - 2'(pop);
    assign status.room = (occ <= 2'd1);

    // Read tag stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
        end else begin
            pend_v_reg <= cmd.rd_en;
        end
        pend_run_reg  <= cmd.run_end;
        pend_list_reg <= cmd.list_end;
    end

    // Output head and skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= pend_v_reg;
            end else begin
                out_v_reg  <= pend_v_reg;
            end
        end else if (pend_v_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || pop) begin
            if (skid_v_reg) begin
                out_data_reg  <= skid_data_reg;
                out_run_reg   <= skid_run_reg;
                out_list_reg  <= skid_list_reg;
                skid_data_reg <= ram_q;
                skid_run_reg  <= pend_run_reg;
                skid_list_reg <= pend_list_reg;
            end else begin
                out_data_reg  <= ram_q;
                out_run_reg   <= pend_run_reg;
                out_list_reg  <= pend_list_reg;
            end
        end else if (pend_v_reg) begin
            skid_data_reg <= ram_q;
            skid_run_reg  <= pend_run_reg;
            skid_list_reg <= pend_list_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_run_reg;
    assign m_tuser  = out_list_reg;

endmodule : grs_datapath

`default_nettype wire

// File: sv/grs_ctrl.sv
// grs_ctrl: group size register, fill count and the accept/emit sequencer
// that drives buffer writes and ordered reads. Depends on grs_pkg.
`default_nettype none

module grs_ctrl
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [GSIZE_W-1:0]           cfg_wr_data,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire                         s_tlast,
    input  grs_status_t                 status,
    output grs_cmd_t                    cmd,
    output logic [$clog2(MAX_GROUP)-1:0] wr_addr,
    output logic [$clog2(MAX_GROUP)-1:0] rd_addr
);

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_GROUP);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [GSIZE_W-1:0] gsize_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     cnt_reg, cnt_next;    // elements to emit
    logic [CW-1:0]     idx_reg, idx_next;    // next element to emit
    logic              rev_reg, rev_next;
    logic              fin_reg, fin_next;

    logic [KW-1:0] gs_ext, k_wide;
    logic [CW-1:0] k_size, fill_inc, rd_pos;
    logic          accept, has_room, last_rd;

    // Effective group size: zero means one, clamp at buffer depth
    assign gs_ext = KW'(gsize_reg);
    always_comb begin
        if (gs_ext == '0) begin
            k_wide = KW'(1);
        end else if (gs_ext > MAX_K) begin
            k_wide = MAX_K;
        end else begin
            k_wide = gs_ext;
        end
    end
    assign k_size = k_wide[CW-1:0];

    assign accept   = s_tvalid & s_tready;
    assign has_room = (fill_reg < MAX_C);
    assign fill_inc = has_room ? (fill_reg + CW'(1)) : fill_reg;
    assign last_rd  = (idx_reg == (cnt_reg - CW'(1)));
    assign rd_pos   = rev_reg ? (cnt_reg - CW'(1) - idx_reg) : idx_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign wr_addr  = fill_reg[AW-1:0];
    assign rd_addr  = rd_pos[AW-1:0];

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        rev_next     = rev_reg;
        fin_next     = fin_reg;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.run_end  = last_rd;
        cmd.list_end = last_rd & fin_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.wr_en = has_room;
                    fill_next = fill_inc;
                    fin_next  = s_tlast;
                    cnt_next  = fill_inc;
                    idx_next  = '0;
                    if (fill_inc >= k_size) begin
                        rev_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else if (s_tlast) begin
                        rev_next   = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (status.room) begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    if (last_rd) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            gsize_reg <= GSIZE_RESET;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_wr_en) begin
                gsize_reg <= cfg_wr_data;
            end
        end
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        rev_reg <= rev_next;
        fin_reg <= fin_next;
    end

endmodule : grs_ctrl

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking testbench for group_reverse_stream.
// Streams lists through the block under several group sizes and handshake
// patterns and checks every output item against a local reorder predictor.
`timescale 1ns / 1ps

module tb_top;
    import grs_pkg::*;

    localparam int GROUP_DEPTH   = 16;      // matches the block's MAX_GROUP
    localparam int SETTLE_CYCLES = 24;      // quiet time before a config write
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 24;
    localparam int NUM_PHASES    = 10;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
    } list_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      run_end;
        logic                      list_end;
    } reorder_elem_t;

    // Clock, reset and block ports
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [GSIZE_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata     = '0;     // [31:0] value
    logic                 s_tlast     = 1'b0;   // is_final
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [VALUE_W-1:0]   m_tdata;              // [31:0] out_value
    logic                 m_tlast;              // run_end
    logic                 m_tuser;              // [0] list_end

    // Stimulus and expectations
    list_item_t    list_items_q[$];
    reorder_elem_t reorder_due_q[$];

    // Predictor state
    logic [VALUE_W-1:0]   grp_buf [GROUP_DEPTH];
    logic [4:0]           grp_fill     = '0;
    logic [GSIZE_W-1:0]   grp_size_reg = GSIZE_RESET;

    // Handshake shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_id    = 0;
    int hold_req_len   = 0;
    int hold_seen_id   = 0;
    int hold_left      = 0;

    // Bookkeeping
    int mismatches      = 0;
    int items_in        = 0;
    int elems_checked   = 0;
    int lists_closed    = 0;
    int in_stall_cycles = 0;
    int cfg_writes      = 0;
    int cycle_count     = 0;

    group_reverse_stream #(
        .MAX_GROUP (GROUP_DEPTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Buffer one element; emit the group reversed when full, in order on a
    // short final group. Size 0 acts as 1, sizes above the depth saturate.
    task automatic reorder_predict(input logic [VALUE_W-1:0] v, input logic fin);
        int            k;
        int            n;
        bit            flip;
        reorder_elem_t e;
        k = grp_size_reg;
        if (k < 1) k = 1;
        if (k > GROUP_DEPTH) k = GROUP_DEPTH;
        if (grp_fill < GROUP_DEPTH) begin
            grp_buf[grp_fill] = v;
            grp_fill++;
        end
        if (grp_fill >= k) begin
            flip = 1'b1;
        end else if (fin) begin
            flip = 1'b0;
        end else begin
            return;
        end
        n = grp_fill;
        for (int i = 0; i < n; i++) begin
            e.value    = grp_buf[flip ? (n - 1 - i) : i];
            e.run_end  = (i == n - 1);
            e.list_end = (i == n - 1) && fin;
            reorder_due_q.push_back(e);
        end
        grp_fill = '0;
    endtask

    // Input driver: holds tvalid until the item is taken
    always @(posedge aclk) begin : drive_items
        list_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (list_items_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = list_items_q.pop_front();
                s_tdata  <= nxt.value;
                s_tlast  <= nxt.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, or a long hold-off on request
    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req_id != hold_seen_id) begin
            hold_seen_id <= hold_req_id;
            hold_left    <= hold_req_len;
            m_tready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on accepted input items, check accepted output items
    always @(posedge aclk) begin : watch_channels
        reorder_elem_t want;
        if (aresetn) begin
            if (s_tvalid && !s_tready) in_stall_cycles++;
            if (s_tvalid && s_tready) begin
                reorder_predict(s_tdata, s_tlast);
                items_in++;
            end
            if (m_tvalid && m_tready) begin
                if (reorder_due_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item: expected none, actual value %0d",
                             $time, $signed(m_tdata));
                end else begin
                    want = reorder_due_q.pop_front();
                    elems_checked++;
                    if (want.list_end) lists_closed++;
                    if ($signed(m_tdata) !== want.value) begin
                        mismatches++;
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want.value, $signed(m_tdata));
                    end
                    if (m_tlast !== want.run_end) begin
                        mismatches++;
                        $display("%0t: run_end mismatch: expected %b, actual %b",
                                 $time, want.run_end, m_tlast);
                    end
                    if (m_tuser !== want.list_end) begin
                        mismatches++;
                        $display("%0t: list_end mismatch: expected %b, actual %b",
                                 $time, want.list_end, m_tuser);
                    end
                end
            end
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [VALUE_W-1:0] v, input logic fin);
        list_item_t it;
        it.value = v;
        it.last  = fin;
        list_items_q.push_back(it);
    endtask

    // Wait for the sender to drain and every expected item to arrive
    task automatic settle();
        while (list_items_q.size() != 0 || s_tvalid || reorder_due_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_group_size(input logic [GSIZE_W-1:0] k);
        @(posedge aclk);
        cfg_wr_data <= k;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grp_size_reg = k;
        cfg_writes++;
    endtask

    // Mostly complete lists with random content, some stray single items
    task automatic queue_random_lists(input int eff_k, input int n_items);
        int added;
        int len;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, 2 * eff_k + 3);
                for (int j = 0; j < len; j++)
                    push_item(rand_value(), j == len - 1);
                added += len;
            end else begin
                push_item(rand_value(), 1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    // Main sequence
    initial begin : run_sequence
        logic [GSIZE_W-1:0] phase_sizes [NUM_PHASES];
        int                 eff_k;
        int                 mode;
        phase_sizes = '{5'd16, 5'd3, 5'd0, 5'd7, 5'd16, 5'd1, 5'd31, 5'd5, 5'd2, 5'd9};
        phase_sizes[NUM_PHASES-1] = 5'($urandom_range(0, 31));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset size of 2: final item completes a group, then a one-item list
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hffff_ffff, 1'b1);
        push_item(32'h0000_0005, 1'b1);
        settle();

        // Size zero passes through
        write_group_size(5'd0);
        push_item(32'h0000_0011, 1'b0);
        push_item(32'h0000_0022, 1'b1);
        settle();

        // Short list comes out unchanged, then leave two items buffered
        write_group_size(5'd5);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h0000_0002, 1'b0);
        push_item(32'h0000_0003, 1'b1);
        push_item(32'h0000_0004, 1'b0);
        push_item(32'h0000_0005, 1'b0);
        settle();

        // Shrink mid-group: the whole buffer flushes reversed
        write_group_size(5'd2);
        push_item(32'h0000_0006, 1'b0);
        settle();

        // Oversize saturates to a full group of 16
        write_group_size(5'd31);
        for (int i = 0; i < GROUP_DEPTH; i++)
            push_item(32'h0000_0100 + i, i == GROUP_DEPTH - 1);
        settle();

        // Random phases across sizes and handshake patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_group_size(phase_sizes[p]);
            eff_k = phase_sizes[p];
            if (eff_k < 1) eff_k = 1;
            if (eff_k > GROUP_DEPTH) eff_k = GROUP_DEPTH;
            mode = p % 4;
            if (p == PRESSURE_PHASE) mode = 0;
            case (mode)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 52; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 52; end
                default: begin send_idle_pct <= 18; recv_stall_pct <= 18; end
            endcase
            if (p == PRESSURE_PHASE) begin
                // receiver backs off while the sender keeps offering
                hold_req_len <= HOLD_CYCLES;
                hold_req_id  <= hold_req_id + 1;
            end
            @(posedge aclk);
            queue_random_lists(eff_k, PHASE_ITEMS);
            settle();
        end

        $display("Covered %0d input items, %0d output items checked, %0d lists closed,",
                 items_in, elems_checked, lists_closed);
        $display("%0d group size writes, %0d cycles with the input stalled",
                 cfg_writes, in_stall_cycles);
        if (mismatches == 0 && reorder_due_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
